// ----- src/sdspi_pkg.sv -----
// shared types, constants and the crc7 helper for the sd spi command engine
// no dependencies
package sdspi_pkg;

    localparam int POLL_LIMIT       = 2048;
    localparam int IDLE_CLOCK_BYTES = 32;

    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_CLOSE = 3'd3;
    localparam logic [2:0] OP_STOP  = 3'd4;
    localparam logic [2:0] OP_BYTE  = 3'd5;

    localparam logic [7:0] CMD0   = 8'h40;
    localparam logic [7:0] CMD1   = 8'h41;
    localparam logic [7:0] CMD8   = 8'h48;
    localparam logic [7:0] CMD12  = 8'h4C;
    localparam logic [7:0] CMD18  = 8'h52;
    localparam logic [7:0] CMD25  = 8'h59;
    localparam logic [7:0] ACMD41 = 8'h69;
    localparam logic [7:0] CMD55  = 8'h77;
    localparam logic [7:0] CMD58  = 8'h7A;

    localparam logic [31:0] ARG_CMD8    = 32'h0000_01AA;
    localparam logic [31:0] ARG_V2_55   = 32'h0000_FFFF;
    localparam logic [31:0] ARG_V2_41   = 32'h4030_0000;
    localparam logic [31:0] CLOSED_MARK = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] sector_address;
        logic [15:0] block_count;
        logic        forced;
        logic [7:0]  card_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       chip_select;
        logic       byte_pending;
        logic [3:0] status;
        logic       card_high_capacity;
    } res_t;

    // crc7 of the five command bytes, end bit set; only evaluated on constants
    function automatic logic [7:0] crc7_frame(input logic [7:0] cmd, input logic [31:0] arg);
        logic [39:0] m;
        logic [7:0]  c;
        logic        top;
        m = {cmd, arg};
        c = 8'h00;
        for (int i = 0; i < 5; i++)
        begin
            c = c ^ m[39 - 8 * i -: 8];
            for (int k = 0; k < 8; k++)
            begin
                top = c[7];
                c = {c[6:0], 1'b0};
                if (top)
                begin
                    c = c ^ 8'h12;
                end
            end
        end
        return {c[7:1], 1'b1};
    endfunction

    localparam logic [7:0] CRC_CMD0   = crc7_frame(CMD0, 32'd0);
    localparam logic [7:0] CRC_CMD1   = crc7_frame(CMD1, 32'd0);
    localparam logic [7:0] CRC_CMD8   = crc7_frame(CMD8, ARG_CMD8);
    localparam logic [7:0] CRC_V2_55  = crc7_frame(CMD55, ARG_V2_55);
    localparam logic [7:0] CRC_V2_41  = crc7_frame(ACMD41, ARG_V2_41);
    localparam logic [7:0] CRC_V1_55  = crc7_frame(CMD55, 32'd0);
    localparam logic [7:0] CRC_V1_41  = crc7_frame(ACMD41, 32'd0);
    localparam logic [7:0] CRC_CMD58  = crc7_frame(CMD58, 32'd0);

endpackage

// ----- src/sdspi_req_if.sv -----
// request channel: opcode, sector, count, stop flag and returned card word
// depends on nothing
interface sdspi_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] sector_address;
    logic [15:0] block_count;
    logic        forced;
    logic [7:0]  card_byte;

    modport source (output valid, opcode, sector_address, block_count, forced, card_byte,
                    input ready);
    modport sink (input valid, opcode, sector_address, block_count, forced, card_byte,
                  output ready);
endinterface

// ----- src/sdspi_res_if.sv -----
// result channel: next link word, select, pending flag, status, capacity flag
// depends on nothing
interface sdspi_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] mosi_byte;
    logic       chip_select;
    logic       byte_pending;
    logic [3:0] status;
    logic       card_high_capacity;

    modport source (output valid, mosi_byte, chip_select, byte_pending, status,
                    card_high_capacity, input ready);
    modport sink (input valid, mosi_byte, chip_select, byte_pending, status,
                  card_high_capacity, output ready);
endinterface

// ----- src/sd_spi_command_engine_core.sv -----
// a request word is registered in the input stage, its result word in the result register
// throughput: one request or card word per cycle while the result channel accepts, set by the single-step sequencer
// a held result does not block intake while the input stage is free
// reset (rst_n low, async): sequencer idle, card not initialized, no read session open
// top level: input stage, sequencer, result register; depends on sdspi_pkg and the channel ifs
module sd_spi_command_engine_core import sdspi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sdspi_req_if.sink   req,
    sdspi_res_if.source res
);

    logic s1_valid_reg;
    req_t s1_reg;
    logic out_valid_reg;
    res_t out_reg;
    logic advance;
    logic eng_valid;
    res_t eng_res;

    assign advance   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !s1_valid_reg || advance;

    sdspi_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .item      (s1_reg),
        .res_valid (eng_valid),
        .result    (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= eng_valid;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_reg.opcode         <= req.opcode;
            s1_reg.sector_address <= req.sector_address;
            s1_reg.block_count    <= req.block_count;
            s1_reg.forced         <= req.forced;
            s1_reg.card_byte      <= req.card_byte;
        end
        if (advance && eng_valid)
        begin
            out_reg <= eng_res;
        end
    end

    assign res.valid              = out_valid_reg;
    assign res.mosi_byte          = out_reg.mosi_byte;
    assign res.chip_select        = out_reg.chip_select;
    assign res.byte_pending       = out_reg.byte_pending;
    assign res.status             = out_reg.status;
    assign res.card_high_capacity = out_reg.card_high_capacity;

endmodule

// ----- src/sdspi_engine.sv -----
// command sequencer state and one-step next-state logic
// depends on sdspi_pkg
module sdspi_engine import sdspi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step_en,
    input  req_t item,
    output logic res_valid,
    output res_t result
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_I_CLOSE, PH_I_CLOCKS, PH_I_CMD0, PH_I_CMD8, PH_I_CMD8_TAIL,
        PH_I2_CMD55, PH_I2_CMD41, PH_I2_CMD58, PH_I2_OCR,
        PH_I1_CMD55, PH_I1_CMD41, PH_I1L_CMD55, PH_I1L_CMD41, PH_I1L_CMD1,
        PH_S_CMD0, PH_R_CLOSE, PH_R_CMD18, PH_W_CMD25, PH_C_CMD12
    } phase_t;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_CMD0      = 4'd1;
    localparam logic [3:0] ST_CMD8      = 4'd2;
    localparam logic [3:0] ST_V2_55     = 4'd3;
    localparam logic [3:0] ST_V2_41     = 4'd4;
    localparam logic [3:0] ST_V2_TMO    = 4'd5;
    localparam logic [3:0] ST_CMD58     = 4'd6;
    localparam logic [3:0] ST_V1_55     = 4'd7;
    localparam logic [3:0] ST_V1_41     = 4'd8;
    localparam logic [3:0] ST_V1L_55    = 4'd9;
    localparam logic [3:0] ST_V1L_41    = 4'd10;
    localparam logic [3:0] ST_V1_TMO    = 4'd11;
    localparam logic [3:0] ST_READ      = 4'd12;
    localparam logic [3:0] ST_WRITE     = 4'd13;

    localparam logic [11:0] POLL_MAX  = 12'(POLL_LIMIT);
    localparam logic [11:0] CLOCK_MAX = 12'(IDLE_CLOCK_BYTES - 1);

    phase_t      phase_reg, phase_next;
    logic [3:0]  byte_index_reg, byte_index_next;
    logic [11:0] poll_count_reg, poll_count_next;
    logic [11:0] loop_count_reg, loop_count_next;
    logic [47:0] frame_reg, frame_next;
    logic [7:0]  last_resp_reg, last_resp_next;
    logic        version_two_reg, version_two_next;
    logic        high_cap_reg, high_cap_next;
    logic        initialized_reg, initialized_next;
    logic [31:0] next_sector_reg, next_sector_next;
    logic [31:0] req_sector_reg, req_sector_next;
    logic [15:0] req_count_reg, req_count_next;

    logic        do_emit, emit_cs;
    logic [7:0]  emit_mosi;
    logic        do_fin;
    logic [3:0]  fin_status;
    logic        do_send, snd_fast;
    phase_t      snd_phase;
    logic [7:0]  snd_cmd, snd_crc;
    logic [31:0] snd_arg;
    logic        do_resp, do_after8, do_v2, do_v1;
    logic [7:0]  b;
    logic [3:0]  bi_inc;

    function automatic logic [31:0] media_addr(input logic hc, input logic [31:0] s);
        return hc ? s : {s[22:0], 9'd0};
    endfunction

    always_comb
    begin
        phase_next       = phase_reg;
        byte_index_next  = byte_index_reg;
        poll_count_next  = poll_count_reg;
        loop_count_next  = loop_count_reg;
        frame_next       = frame_reg;
        last_resp_next   = last_resp_reg;
        version_two_next = version_two_reg;
        high_cap_next    = high_cap_reg;
        initialized_next = initialized_reg;
        next_sector_next = next_sector_reg;
        req_sector_next  = req_sector_reg;
        req_count_next   = req_count_reg;
        res_valid  = 1'b0;
        do_emit    = 1'b0;
        emit_cs    = 1'b0;
        emit_mosi  = 8'hFF;
        do_fin     = 1'b0;
        fin_status = ST_OK;
        do_send    = 1'b0;
        snd_fast   = 1'b0;
        snd_phase  = PH_IDLE;
        snd_cmd    = CMD0;
        snd_arg    = 32'd0;
        snd_crc    = 8'hFF;
        do_resp    = 1'b0;
        do_after8  = 1'b0;
        do_v2      = 1'b0;
        do_v1      = 1'b0;
        b          = item.card_byte;
        bi_inc     = byte_index_reg + 4'd1;

        unique case (item.opcode)
            OP_INIT:
            begin
                res_valid = 1'b1;
                initialized_next = 1'b0;
                high_cap_next = 1'b0;
                version_two_next = 1'b0;
                if (next_sector_reg != CLOSED_MARK)
                begin
                    next_sector_next = CLOSED_MARK;
                    do_send = 1'b1; snd_phase = PH_I_CLOSE; snd_cmd = CMD12; snd_fast = 1'b1;
                end
                else
                begin
                    phase_next = PH_I_CLOCKS;
                    loop_count_next = 12'd0;
                    do_emit = 1'b1;
                end
            end
            OP_READ:
            begin
                res_valid = 1'b1;
                if (item.sector_address == next_sector_reg)
                begin
                    next_sector_next = next_sector_reg + 32'(item.block_count);
                    do_fin = 1'b1;
                end
                else
                begin
                    req_sector_next = item.sector_address;
                    req_count_next = item.block_count;
                    do_send = 1'b1; snd_fast = 1'b1;
                    if (next_sector_reg != CLOSED_MARK)
                    begin
                        next_sector_next = CLOSED_MARK;
                        snd_phase = PH_R_CLOSE; snd_cmd = CMD12;
                    end
                    else
                    begin
                        snd_phase = PH_R_CMD18; snd_cmd = CMD18;
                        snd_arg = media_addr(high_cap_reg, item.sector_address);
                    end
                end
            end
            OP_WRITE:
            begin
                res_valid = 1'b1;
                do_send = 1'b1; snd_fast = 1'b1; snd_phase = PH_W_CMD25; snd_cmd = CMD25;
                snd_arg = media_addr(high_cap_reg, item.sector_address);
            end
            OP_CLOSE:
            begin
                res_valid = 1'b1;
                if (next_sector_reg != CLOSED_MARK)
                begin
                    next_sector_next = CLOSED_MARK;
                    do_send = 1'b1; snd_fast = 1'b1; snd_phase = PH_C_CMD12; snd_cmd = CMD12;
                end
                else
                begin
                    do_fin = 1'b1;
                end
            end
            OP_STOP:
            begin
                res_valid = 1'b1;
                if (!item.forced && !initialized_reg)
                begin
                    do_fin = 1'b1;
                end
                else
                begin
                    loop_count_next = 12'd1;
                    do_send = 1'b1; snd_phase = PH_S_CMD0; snd_cmd = CMD0; snd_crc = CRC_CMD0;
                end
            end
            OP_BYTE:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    res_valid = 1'b1;
                    case (phase_reg)
                        PH_I_CLOCKS:
                        begin
                            if (loop_count_reg < CLOCK_MAX)
                            begin
                                loop_count_next = loop_count_reg + 12'd1;
                                do_emit = 1'b1;
                            end
                            else
                            begin
                                loop_count_next = 12'd1;
                                do_send = 1'b1; snd_phase = PH_I_CMD0;
                                snd_cmd = CMD0; snd_crc = CRC_CMD0;
                            end
                        end
                        PH_I_CMD8_TAIL:
                        begin
                            if (byte_index_reg < 4'd4)
                            begin
                                byte_index_next = bi_inc;
                                do_emit = 1'b1;
                            end
                            else
                            begin
                                do_after8 = 1'b1;
                            end
                        end
                        PH_I2_OCR:
                        begin
                            if (byte_index_reg == 4'd0 && b[6])
                            begin
                                high_cap_next = 1'b1;
                            end
                            if (byte_index_reg < 4'd3)
                            begin
                                byte_index_next = bi_inc;
                                do_emit = 1'b1; emit_cs = 1'b1;
                            end
                            else
                            begin
                                next_sector_next = 32'd1;
                                initialized_next = 1'b1;
                                do_fin = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (byte_index_reg < 4'd8)
                            begin
                                byte_index_next = bi_inc;
                                do_emit = 1'b1; emit_cs = 1'b1;
                                case (bi_inc)
                                    4'd1:    emit_mosi = frame_reg[47:40];
                                    4'd2:    emit_mosi = frame_reg[39:32];
                                    4'd3:    emit_mosi = frame_reg[31:24];
                                    4'd4:    emit_mosi = frame_reg[23:16];
                                    4'd5:    emit_mosi = frame_reg[15:8];
                                    4'd6:    emit_mosi = frame_reg[7:0];
                                    default: emit_mosi = 8'hFF;
                                endcase
                            end
                            else if (byte_index_reg == 4'd8)
                            begin
                                if (b == 8'hFF)
                                begin
                                    byte_index_next = 4'd9;
                                    poll_count_next = 12'd0;
                                    do_emit = 1'b1; emit_cs = 1'b1;
                                end
                                else
                                begin
                                    do_resp = 1'b1;
                                end
                            end
                            else if (b == 8'hFF && poll_count_reg < POLL_MAX)
                            begin
                                poll_count_next = poll_count_reg + 12'd1;
                                do_emit = 1'b1; emit_cs = 1'b1;
                            end
                            else
                            begin
                                do_resp = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase

        // card answered or poll ran out: decide next step of the sequence
        if (do_resp)
        begin
            case (phase_reg)
                PH_I_CLOSE:
                begin
                    phase_next = PH_I_CLOCKS;
                    loop_count_next = 12'd0;
                    do_emit = 1'b1;
                end
                PH_I_CMD0, PH_S_CMD0:
                begin
                    if (b == 8'h01)
                    begin
                        if (phase_reg == PH_S_CMD0)
                        begin
                            do_fin = 1'b1;
                        end
                        else
                        begin
                            do_send = 1'b1; snd_phase = PH_I_CMD8; snd_cmd = CMD8;
                            snd_arg = ARG_CMD8; snd_crc = CRC_CMD8;
                        end
                    end
                    else if (loop_count_reg < 12'd2)
                    begin
                        loop_count_next = loop_count_reg + 12'd1;
                        do_send = 1'b1; snd_phase = phase_reg; snd_cmd = CMD0; snd_crc = CRC_CMD0;
                    end
                    else
                    begin
                        do_fin = 1'b1; fin_status = ST_CMD0;
                    end
                end
                PH_I_CMD8:
                begin
                    last_resp_next = b;
                    byte_index_next = 4'd0;
                    phase_next = PH_I_CMD8_TAIL;
                    do_emit = 1'b1;
                end
                PH_I2_CMD55:
                begin
                    if (b == 8'hFF)
                    begin
                        do_fin = 1'b1; fin_status = ST_V2_55;
                    end
                    else if (b != 8'h01)
                    begin
                        loop_count_next = loop_count_reg + 12'd1;
                        do_v2 = 1'b1;
                    end
                    else
                    begin
                        do_send = 1'b1; snd_phase = PH_I2_CMD41; snd_cmd = ACMD41;
                        snd_arg = ARG_V2_41; snd_crc = CRC_V2_41;
                    end
                end
                PH_I2_CMD41:
                begin
                    if (b == 8'hFF)
                    begin
                        do_fin = 1'b1; fin_status = ST_V2_41;
                    end
                    else if (b != 8'h00)
                    begin
                        loop_count_next = loop_count_reg + 12'd1;
                        do_v2 = 1'b1;
                    end
                    else
                    begin
                        do_send = 1'b1; snd_phase = PH_I2_CMD58; snd_cmd = CMD58;
                        snd_crc = CRC_CMD58;
                    end
                end
                PH_I2_CMD58:
                begin
                    if (b == 8'hFF)
                    begin
                        do_fin = 1'b1; fin_status = ST_CMD58;
                    end
                    else
                    begin
                        phase_next = PH_I2_OCR;
                        byte_index_next = 4'd0;
                        do_emit = 1'b1; emit_cs = 1'b1;
                    end
                end
                PH_I1_CMD55:
                begin
                    if (b == 8'hFF)
                    begin
                        do_fin = 1'b1; fin_status = ST_V1_55;
                    end
                    else
                    begin
                        do_send = 1'b1; snd_phase = PH_I1_CMD41; snd_cmd = ACMD41;
                        snd_crc = CRC_V1_41;
                    end
                end
                PH_I1_CMD41:
                begin
                    if (b == 8'hFF)
                    begin
                        do_fin = 1'b1; fin_status = ST_V1_41;
                    end
                    else
                    begin
                        last_resp_next = b;
                        loop_count_next = 12'd0;
                        do_v1 = 1'b1;
                    end
                end
                PH_I1L_CMD55:
                begin
                    last_resp_next = b;
                    if (b == 8'hFF)
                    begin
                        do_fin = 1'b1; fin_status = ST_V1L_55;
                    end
                    else if (b != 8'h01)
                    begin
                        loop_count_next = loop_count_reg + 12'd1;
                        do_v1 = 1'b1;
                    end
                    else
                    begin
                        do_send = 1'b1; snd_phase = PH_I1L_CMD41; snd_cmd = ACMD41;
                        snd_crc = CRC_V1_41;
                    end
                end
                PH_I1L_CMD41, PH_I1L_CMD1:
                begin
                    last_resp_next = b;
                    if (b == 8'hFF && phase_reg == PH_I1L_CMD41)
                    begin
                        do_fin = 1'b1; fin_status = ST_V1L_41;
                    end
                    else if (b != 8'h00)
                    begin
                        loop_count_next = loop_count_reg + 12'd1;
                        do_v1 = 1'b1;
                    end
                    else
                    begin
                        next_sector_next = 32'd1;
                        initialized_next = 1'b1;
                        do_fin = 1'b1;
                    end
                end
                PH_R_CLOSE:
                begin
                    do_send = 1'b1; snd_fast = 1'b1; snd_phase = PH_R_CMD18; snd_cmd = CMD18;
                    snd_arg = media_addr(high_cap_reg, req_sector_reg);
                end
                PH_R_CMD18:
                begin
                    do_fin = 1'b1;
                    if (b != 8'h00)
                    begin
                        fin_status = ST_READ;
                    end
                    else
                    begin
                        next_sector_next = req_sector_reg + 32'(req_count_reg);
                    end
                end
                PH_W_CMD25:
                begin
                    do_fin = 1'b1;
                    fin_status = (b != 8'h00) ? ST_WRITE : ST_OK;
                end
                default:
                begin
                    do_fin = 1'b1;
                end
            endcase
        end

        if (do_after8)
        begin
            if (last_resp_reg == 8'hFF)
            begin
                do_fin = 1'b1; fin_status = ST_CMD8;
            end
            else
            begin
                if (last_resp_reg != 8'h05)
                begin
                    version_two_next = 1'b1;
                end
                loop_count_next = 12'd0;
                if (version_two_next)
                begin
                    do_v2 = 1'b1;
                end
                else
                begin
                    do_send = 1'b1; snd_phase = PH_I1_CMD55; snd_cmd = CMD55;
                    snd_crc = CRC_V1_55;
                end
            end
        end

        if (do_v2)
        begin
            if (loop_count_next >= POLL_MAX)
            begin
                do_fin = 1'b1; fin_status = ST_V2_TMO;
            end
            else
            begin
                do_send = 1'b1; snd_phase = PH_I2_CMD55; snd_cmd = CMD55;
                snd_arg = ARG_V2_55; snd_crc = CRC_V2_55;
            end
        end

        if (do_v1)
        begin
            if (loop_count_next >= POLL_MAX)
            begin
                do_fin = 1'b1; fin_status = ST_V1_TMO;
            end
            else if (last_resp_next == 8'h00)
            begin
                do_send = 1'b1; snd_phase = PH_I1L_CMD55; snd_cmd = CMD55; snd_crc = CRC_V1_55;
            end
            else
            begin
                do_send = 1'b1; snd_phase = PH_I1L_CMD1; snd_cmd = CMD1; snd_crc = CRC_CMD1;
            end
        end

        result.mosi_byte          = emit_mosi;
        result.chip_select        = emit_cs;
        result.byte_pending       = 1'b1;
        result.status             = ST_OK;
        result.card_high_capacity = high_cap_next;
        if (do_send)
        begin
            frame_next      = {snd_cmd, snd_arg, snd_fast ? 8'hFF : snd_crc};
            phase_next      = snd_phase;
            byte_index_next = 4'd0;
            poll_count_next = 12'd0;
            result.mosi_byte   = 8'hFF;
            result.chip_select = 1'b1;
        end
        else if (do_fin)
        begin
            phase_next      = PH_IDLE;
            byte_index_next = 4'd0;
            poll_count_next = 12'd0;
            result.mosi_byte    = 8'hFF;
            result.chip_select  = 1'b0;
            result.byte_pending = 1'b0;
            result.status       = fin_status;
        end
        else if (!do_emit)
        begin
            result.chip_select = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            byte_index_reg  <= 4'd0;
            poll_count_reg  <= 12'd0;
            loop_count_reg  <= 12'd0;
            frame_reg       <= 48'd0;
            last_resp_reg   <= 8'd0;
            version_two_reg <= 1'b0;
            high_cap_reg    <= 1'b0;
            initialized_reg <= 1'b0;
            next_sector_reg <= CLOSED_MARK;
            req_sector_reg  <= 32'd0;
            req_count_reg   <= 16'd0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            poll_count_reg  <= poll_count_next;
            loop_count_reg  <= loop_count_next;
            frame_reg       <= frame_next;
            last_resp_reg   <= last_resp_next;
            version_two_reg <= version_two_next;
            high_cap_reg    <= high_cap_next;
            initialized_reg <= initialized_next;
            next_sector_reg <= next_sector_next;
            req_sector_reg  <= req_sector_next;
            req_count_reg   <= req_count_next;
        end
    end

    a_fin_idles: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res_valid && !result.byte_pending |=> phase_reg == PH_IDLE)
        else $error("finished word did not return sequencer to idle");

    a_idle_byte_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.opcode == OP_BYTE && phase_reg == PH_IDLE |-> !res_valid)
        else $error("card word while idle produced a result");

    a_fin_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !result.byte_pending |-> result.mosi_byte == 8'hFF && !result.chip_select)
        else $error("finished word carries link data");

    a_poll_bound: assert property (@(posedge clk) disable iff (!rst_n)
        poll_count_reg <= POLL_MAX && loop_count_reg <= POLL_MAX)
        else $error("poll or loop counter beyond limit");

endmodule
